@@ sv/headset_jack_detector_defines.svh @@
// Assertion macros for the headset jack detector RTL.
`ifndef HEADSET_JACK_DETECTOR_DEFINES_SVH
`define HEADSET_JACK_DETECTOR_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define HJD_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define HJD_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

@@ sv/hjd_pkg.sv @@
// Types and constants shared by the headset jack detector modules.
`default_nettype none

package hjd_pkg;

  localparam int TimerBits = 16;
  localparam int CfgDataBits = 16;
  localparam int CfgIndexBits = 3;
  localparam int ModeBits = 3;

  typedef enum logic [1:0] {
    JackNone  = 2'd0,
    JackFour  = 2'd1,
    JackThree = 2'd2
  } jack_t;

  typedef enum logic [1:0] {
    KeyNone    = 2'd0,
    KeyPress   = 2'd1,
    KeyRelease = 2'd2
  } key_t;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgInsertDebounce  = 3'd0,
    CfgUnplugDebounce  = 3'd1,
    CfgPressDebounce   = 3'd2,
    CfgReleaseDebounce = 3'd3,
    CfgFirstPressDelay = 3'd4,
    CfgButtonEnable    = 3'd5,
    CfgPoleSettle      = 3'd6,
    CfgModeFlags       = 3'd7
  } cfg_idx_t;

  // Bit positions inside mode_flags.
  localparam int ModeDetectLow = 0;
  localparam int ModeButtonLow = 1;
  localparam int ModeAdaptive  = 2;

  typedef struct packed {
    logic [CfgDataBits-1:0] insert_debounce;
    logic [CfgDataBits-1:0] unplug_debounce;
    logic [CfgDataBits-1:0] press_debounce;
    logic [CfgDataBits-1:0] release_debounce;
    logic [CfgDataBits-1:0] first_press_delay;
    logic [CfgDataBits-1:0] button_enable_delay;
    logic [CfgDataBits-1:0] pole_settle;
    logic [ModeBits-1:0]    mode;
  } hjd_cfg_t;

  localparam hjd_cfg_t CfgReset = '{
    insert_debounce:     16'd250,
    unplug_debounce:     16'd10,
    press_debounce:      16'd40,
    release_debounce:    16'd30,
    first_press_delay:   16'd500,
    button_enable_delay: 16'd1000,
    pole_settle:         16'd100,
    mode:                3'd7
  };

  typedef struct packed {
    jack_t                jack_code;
    logic [TimerBits-1:0] plug_timer;
    logic                 plug_run;
    logic [TimerBits-1:0] settle_timer;
    logic                 settling;
    logic [TimerBits-1:0] button_timer;
    logic                 button_run;
    logic [TimerBits-1:0] enable_timer;
    logic                 enable_pending;
    logic                 sense_on;
    logic                 first_armed;
    logic                 key_held;
    logic                 ignore_button;
    logic                 upgrade_pending;
    logic                 last_detect;
    logic                 last_button;
    logic                 mic_on;
  } hjd_state_t;

  localparam hjd_state_t StateReset = '{
    jack_code:       JackNone,
    plug_timer:      '0,
    plug_run:        1'b0,
    settle_timer:    '0,
    settling:        1'b0,
    button_timer:    '0,
    button_run:      1'b0,
    enable_timer:    '0,
    enable_pending:  1'b0,
    sense_on:        1'b0,
    first_armed:     1'b0,
    key_held:        1'b0,
    ignore_button:   1'b0,
    upgrade_pending: 1'b0,
    last_detect:     1'b1,
    last_button:     1'b1,
    mic_on:          1'b0
  };

  typedef struct packed {
    jack_t jack_state;
    logic  mic_mode;
    key_t  key_event;
    logic  state_changed;
  } hjd_result_t;

endpackage

`default_nettype wire

@@ sv/hjd_cfg_regs.sv @@
// Configuration register bank of the headset jack detector.
`default_nettype none

module hjd_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hjd_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [hjd_pkg::CfgDataBits-1:0]  cfg_data,
  output hjd_pkg::hjd_cfg_t                    cfg
);
  import hjd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CfgInsertDebounce:  cfg.insert_debounce     <= cfg_data;
        CfgUnplugDebounce:  cfg.unplug_debounce     <= cfg_data;
        CfgPressDebounce:   cfg.press_debounce      <= cfg_data;
        CfgReleaseDebounce: cfg.release_debounce    <= cfg_data;
        CfgFirstPressDelay: cfg.first_press_delay   <= cfg_data;
        CfgButtonEnable:    cfg.button_enable_delay <= cfg_data;
        CfgPoleSettle:      cfg.pole_settle         <= cfg_data;
        CfgModeFlags:       cfg.mode                <= cfg_data[ModeBits-1:0];
        default:            cfg <= cfg;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/hjd_core.sv @@
// Detection state and per-tick update logic of the headset jack detector.
`default_nettype none
`include "headset_jack_detector_defines.svh"

module hjd_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            detect,
  input  wire logic            button,
  input  wire hjd_pkg::hjd_cfg_t cfg,
  output hjd_pkg::hjd_result_t res
);
  import hjd_pkg::*;

  hjd_state_t st;
  hjd_state_t st_next;

  logic attached;
  logic pressed;
  logic adaptive;
  logic fire_button;
  logic fire_enable;
  logic fire_settle;
  logic fire_plug;
  logic run_det;
  key_t key;

  assign adaptive = cfg.mode[ModeAdaptive];
  assign attached = detect ^ cfg.mode[ModeDetectLow];
  assign pressed  = button ^ cfg.mode[ModeButtonLow];

  // A running timer fires on the tick it would count from one (or zero) down.
  assign fire_button = st.button_run     && (st.button_timer <= TimerBits'(1));
  assign fire_enable = st.enable_pending && (st.enable_timer <= TimerBits'(1));
  assign fire_settle = st.settling       && (st.settle_timer <= TimerBits'(1));
  assign fire_plug   = st.plug_run       && (st.plug_timer   <= TimerBits'(1));

  always_comb begin
    st_next = st;
    key = KeyNone;
    run_det = st.upgrade_pending;

    // Count down all running timers; a fired timer stops at zero.
    if (fire_button) begin
      st_next.button_timer = '0;
      st_next.button_run = 1'b0;
    end else if (st.button_run) begin
      st_next.button_timer = st.button_timer - TimerBits'(1);
    end
    if (fire_enable) begin
      st_next.enable_timer = '0;
      st_next.enable_pending = 1'b0;
    end else if (st.enable_pending) begin
      st_next.enable_timer = st.enable_timer - TimerBits'(1);
    end
    if (fire_settle) begin
      st_next.settle_timer = '0;
      st_next.settling = 1'b0;
    end else if (st.settling) begin
      st_next.settle_timer = st.settle_timer - TimerBits'(1);
    end
    if (fire_plug) begin
      st_next.plug_timer = '0;
      st_next.plug_run = 1'b0;
    end else if (st.plug_run) begin
      st_next.plug_timer = st.plug_timer - TimerBits'(1);
    end

    // Button debounce expired: key events, or an upgrade request for 3-pole.
    if (fire_button && !(st_next.ignore_button && !adaptive) && attached) begin
      if (st_next.jack_code == JackFour) begin
        if (pressed) begin
          if (!st_next.key_held && !st_next.ignore_button) begin
            st_next.key_held = 1'b1;
            key = KeyPress;
          end
        end else if (st_next.key_held) begin
          st_next.key_held = 1'b0;
          key = KeyRelease;
        end
      end else if (st_next.jack_code == JackThree && adaptive && !pressed) begin
        st_next.upgrade_pending = 1'b1;
      end
    end

    if (fire_enable) begin
      st_next.first_armed = 1'b1;
      st_next.sense_on = 1'b1;
    end

    // Settle wait over: classify by the button line.
    if (fire_settle) begin
      if (!pressed) begin
        st_next.ignore_button = 1'b0;
        st_next.jack_code = JackFour;
        st_next.mic_on = 1'b1;
        st_next.enable_timer = TimerBits'(cfg.button_enable_delay);
        st_next.enable_pending = 1'b1;
      end else begin
        st_next.ignore_button = 1'b1;
        st_next.jack_code = JackThree;
        if (adaptive) begin
          st_next.enable_timer = TimerBits'(cfg.button_enable_delay);
          st_next.enable_pending = 1'b1;
        end
      end
    end

    if (fire_plug) begin
      run_det = 1'b1;
    end

    if (run_det) begin
      if (!attached) begin
        if (st_next.jack_code != JackNone) begin
          st_next.jack_code = JackNone;
          st_next.enable_pending = 1'b0;
          st_next.enable_timer = '0;
          st_next.sense_on = 1'b0;
          st_next.settling = 1'b0;
          st_next.settle_timer = '0;
          if (st_next.key_held) begin
            st_next.key_held = 1'b0;
            key = KeyRelease;
          end
          st_next.mic_on = 1'b0;
        end
      end else if (st_next.jack_code == JackNone || st_next.upgrade_pending) begin
        st_next.settle_timer = TimerBits'(cfg.pole_settle);
        st_next.settling = 1'b1;
      end
      st_next.upgrade_pending = 1'b0;
    end

    // Detect edge restarts the plug debounce and cancels button and settle work.
    if (detect != st.last_detect) begin
      st_next.plug_timer = (st_next.jack_code == JackNone) ?
                           TimerBits'(cfg.insert_debounce) :
                           TimerBits'(cfg.unplug_debounce);
      st_next.plug_run = 1'b1;
      st_next.button_run = 1'b0;
      st_next.button_timer = '0;
      st_next.settling = 1'b0;
      st_next.settle_timer = '0;
      if (!attached) begin
        st_next.mic_on = 1'b0;
      end
    end

    // Button edge starts its debounce; the first edge after enable uses the first-press delay.
    if (button != st.last_button && st_next.sense_on) begin
      if (st_next.first_armed) begin
        st_next.button_timer = TimerBits'(cfg.first_press_delay);
        st_next.first_armed = 1'b0;
      end else if (pressed) begin
        st_next.button_timer = TimerBits'(cfg.press_debounce);
      end else begin
        st_next.button_timer = TimerBits'(cfg.release_debounce);
      end
      st_next.button_run = 1'b1;
    end

    st_next.last_detect = detect;
    st_next.last_button = button;

    res.jack_state = st_next.jack_code;
    res.mic_mode = st_next.mic_on;
    res.key_event = key;
    res.state_changed = (st_next.jack_code != st.jack_code);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateReset;
    end else if (step) begin
      st <= st_next;
    end
  end

  `HJD_ASSERT(a_press_sets_held, clk, rst,
              (step && res.key_event == KeyPress) |=> st.key_held, "press without key held")
  `HJD_ASSERT(a_release_clears_held, clk, rst,
              (step && res.key_event == KeyRelease) |=> !st.key_held, "release left key held")
  `HJD_ASSERT(a_mic_needs_jack, clk, rst,
              st.mic_on |-> (st.jack_code != JackNone), "mic on with no jack")
  `HJD_ASSERT(a_state_holds_idle, clk, rst,
              !step |=> (st == $past(st)), "state moved without a tick")

endmodule

`default_nettype wire

@@ sv/hjd_out_stage.sv @@
// Result register of the headset jack detector with its output handshake.
`default_nettype none

module hjd_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire hjd_pkg::hjd_result_t res,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic                 free,
  output hjd_pkg::hjd_result_t held
);
  import hjd_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

@@ sv/headset_jack_detector.sv @@
// Top level of the headset jack detector: input register, state update and result register.
`default_nettype none

// Each input beat is one time tick carrying the raw jack-detect and button pin levels,
// and each tick produces exactly one result beat with the jack state, the mic mode
// level, a press or release key event and a flag that marks a change of jack state.
// A beat is captured in an input register, the whole tick update (timer countdown,
// plug decision, pole classification, button debounce) is done in one pass of short
// logic, and the result is held in an output register. The block takes one beat per
// clock cycle while out_ready is high; when the output stalls, the input register can
// still take the next tick while a result waits. All debounce and delay timers are
// 16-bit down counters that stop at zero; a load of zero or one fires on the next tick.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and
// should only change while no tick is in flight; writes take effect at once and all
// registers return to their documented defaults on rst.

module headset_jack_detector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [hjd_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [hjd_pkg::CfgDataBits-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             detect_level,
  input  wire logic                             button_level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            jack_state,
  output logic                                  mic_mode,
  output logic [1:0]                            key_event,
  output logic                                  state_changed
);
  import hjd_pkg::*;

  hjd_cfg_t    cfg;
  hjd_result_t res;
  hjd_result_t held;

  // Input register: one tick waiting for its update pass.
  logic in_full;
  logic in_detect;
  logic in_button;

  logic out_free;
  logic step;
  logic in_accept;

  // The held tick is processed as soon as the result register can take its result.
  assign step      = in_full && out_free;
  assign in_ready  = !in_full || step;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_detect <= detect_level;
      in_button <= button_level;
    end
  end

  hjd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hjd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .detect (in_detect),
    .button (in_button),
    .cfg    (cfg),
    .res    (res)
  );

  hjd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .held      (held)
  );

  assign jack_state    = held.jack_state;
  assign mic_mode      = held.mic_mode;
  assign key_event     = held.key_event;
  assign state_changed = held.state_changed;

endmodule

`default_nettype wire
